/* hw/rtl/rfsc_pkg.sv */
// ----------------------------------------------------------------------------
// rfsc_pkg
// Shared types and constants for the row FIR smear convolver.
// ----------------------------------------------------------------------------
package rfsc_pkg;

   localparam int MAX_TAPS = 16;
   localparam int TAP_W    = $clog2(MAX_TAPS);
   localparam int NT_W     = $clog2(MAX_TAPS + 1);

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_SCI  = 2'd1;
   localparam logic [1:0] CMD_ERR  = 2'd2;
   localparam logic [1:0] CMD_QUAL = 2'd3;

   localparam logic [1:0] PLANE_SCI  = 2'd0;
   localparam logic [1:0] PLANE_ERR  = 2'd1;
   localparam logic [1:0] PLANE_QUAL = 2'd2;

   localparam logic [1:0] CSR_ROW_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_EDGE_BORDER = 2'd1;
   localparam logic [1:0] CSR_TAP_COUNT   = 2'd2;
   localparam logic [1:0] CSR_CENTER_TAP  = 2'd3;

   typedef struct packed {
      logic shift;   // new pixel enters the delay chain
      logic load;    // copy delay value into the work chain
      logic rot;     // work chain moves one cell toward the head
   } cell_ctrl_type;

   typedef struct packed {
      logic       clear;
      logic       issue;
      logic [1:0] mode;
   } mac_ctrl_type;

endpackage

/* hw/rtl/row_fir_smear_convolver_top.sv */
// ----------------------------------------------------------------------------
// row_fir_smear_convolver_top
// Row convolver for science, error and quality planes on a chain of tap cells.
// ----------------------------------------------------------------------------
// A tap load, or a pixel that yields no result, leaves the block idle. A
// pixel with results is worked one result at a time through the load, run,
// drain and finish states: in run the window is walked one tap per cycle
// through a single shared multiply-accumulate pipe while the work copy of
// the delay chain moves toward its head. Error-plane results also pass the
// bit-serial square root. A pixel near the row end yields up to
// center_tap + 1 results; no new item is taken until the last one is taken.
module row_fir_smear_convolver_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_pixel_value,
   input  logic [3:0]         req_tap_index,
   input  logic [15:0]        req_tap_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_plane,
   output logic               rsp_run_last,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import rfsc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_SQRT  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [15:0] row_length_ff, row_length_in;
   logic [7:0]  edge_border_ff, edge_border_in;
   logic [4:0]  tap_count_ff, tap_count_in;
   logic [2:0]  center_tap_ff, center_tap_in;
   logic [15:0] taps_ff [MAX_TAPS];
   logic [15:0] column_count_ff, column_count_in;
   logic [1:0]  row_plane_ff, row_plane_in;
   logic [2:0]  state_ff, state_in;
   logic [3:0]  f_ff, f_in, f1_ff, f1_in;
   logic [NT_W-1:0] j_ff, j_in, nt_ff, nt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        accept, pix_accept, tap_write, row_start, last, issue, out_take;
   logic [1:0]  plane_now;
   logic [15:0] len;
   logic [16:0] c_sum;
   logic [31:0] v_new;
   logic [3:0]  f0, f1;
   logic [NT_W:0] tap_sum;
   logic [TAP_W-1:0] tap_addr;
   logic [NT_W-1:0]  nt_clamp;
   logic signed [63:0] sci_sum, sci_shift;
   logic [31:0] sci_val;

   cell_ctrl_type cell_ctrl;
   mac_ctrl_type  mac_ctrl;
   logic [31:0]   d_chain [MAX_TAPS];
   logic [31:0]   w_chain [MAX_TAPS];
   logic [63:0]   acc;
   logic          mac_busy, sqrt_start, sqrt_done;
   logic [31:0]   sqrt_root;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid & ~req_stall;
   assign pix_accept = accept & (req_cmd != CMD_LOAD);
   assign tap_write  = accept & (req_cmd == CMD_LOAD) & (32'(req_tap_index) < MAX_TAPS);
   assign out_take   = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      row_start = (column_count_ff == 16'd0);
      plane_now = row_start ? (req_cmd - 2'd1) : row_plane_ff;
      len       = (row_length_ff == 16'd0) ? 16'd1 : row_length_ff;
      c_sum     = {1'b0, column_count_ff} + {9'd0, edge_border_ff};
      v_new     = req_pixel_value;
      if (plane_now == PLANE_SCI &&
          (column_count_ff < {8'd0, edge_border_ff} || c_sum >= {1'b0, len})) begin
         v_new = 32'd0;
      end
      if (plane_now == PLANE_QUAL) begin
         v_new = {16'd0, req_pixel_value[15:0]};
      end
      last = ({1'b0, column_count_ff} + 17'd1 >= {1'b0, len});
      f0   = (column_count_ff >= {13'd0, center_tap_ff}) ? 4'd0
           : 4'({1'b0, center_tap_ff} - column_count_ff[3:0]);
      f1   = last ? {1'b0, center_tap_ff} : 4'd0;
      nt_clamp = (32'(tap_count_ff) > MAX_TAPS) ? NT_W'(MAX_TAPS) : NT_W'(tap_count_ff);
      tap_sum  = {1'b0, j_ff} + (NT_W + 1)'(f_ff);
      issue    = (state_ff == ST_RUN) && (tap_sum < {1'b0, nt_ff});
      tap_addr = tap_sum[TAP_W-1:0];

      sci_sum   = $signed(acc) + 64'sd32768;
      sci_shift = sci_sum >>> 16;
      if (sci_shift > 64'sd2147483647) begin
         sci_val = 32'h7FFF_FFFF;
      end else if (sci_shift < -64'sd2147483648) begin
         sci_val = 32'h8000_0000;
      end else begin
         sci_val = sci_shift[31:0];
      end
   end

   // config registers and tap store
   always_comb begin
      row_length_in  = row_length_ff;
      edge_border_in = edge_border_ff;
      tap_count_in   = tap_count_ff;
      center_tap_in  = center_tap_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_LENGTH:  row_length_in  = csr_data;
            CSR_EDGE_BORDER: edge_border_in = csr_data[7:0];
            CSR_TAP_COUNT:   tap_count_in   = csr_data[4:0];
            CSR_CENTER_TAP:  center_tap_in  = csr_data[2:0];
            default:         row_length_in  = row_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            taps_ff[i] <= 16'd0;
         end
      end else if (tap_write) begin
         taps_ff[req_tap_index[TAP_W-1:0]] <= req_tap_value;
      end
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      column_count_in = column_count_ff;
      row_plane_in    = row_plane_ff;
      f_in            = f_ff;
      f1_in           = f1_ff;
      j_in            = j_ff;
      nt_in           = nt_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;
      sqrt_start      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pix_accept) begin
               row_plane_in    = plane_now;
               column_count_in = last ? 16'd0 : column_count_ff + 16'd1;
               f_in            = f0;
               f1_in           = f1;
               nt_in           = nt_clamp;
               if (f0 <= f1) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            j_in     = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (issue) begin
               j_in = j_ff + NT_W'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            rsp_last_in = (f_ff == f1_ff);
            if (row_plane_ff == PLANE_ERR) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end else begin
               rsp_value_in = (row_plane_ff == PLANE_SCI) ? sci_val : {16'd0, acc[15:0]};
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               rsp_value_in = sqrt_root;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_take) begin
               rsp_valid_in = 1'b0;
               if (f_ff == f1_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  f_in     = f_ff + 4'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff   <= 16'd1024;
         edge_border_ff  <= 8'd0;
         tap_count_ff    <= 5'd1;
         center_tap_ff   <= 3'd0;
         column_count_ff <= 16'd0;
         row_plane_ff    <= PLANE_SCI;
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         row_length_ff   <= row_length_in;
         edge_border_ff  <= edge_border_in;
         tap_count_ff    <= tap_count_in;
         center_tap_ff   <= center_tap_in;
         column_count_ff <= column_count_in;
         row_plane_ff    <= row_plane_in;
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      f_ff         <= f_in;
      f1_ff        <= f1_in;
      j_ff         <= j_in;
      nt_ff        <= nt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // tap cell chain; a row start flushes the older entries to zero
   assign cell_ctrl.shift = pix_accept;
   assign cell_ctrl.load  = (state_ff == ST_LOAD);
   assign cell_ctrl.rot   = issue;

   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      logic [31:0] d_prev, w_next;
      if (i == 0) begin : g_head
         assign d_prev = v_new;
      end else begin : g_body
         assign d_prev = row_start ? 32'd0 : d_chain[i-1];
      end
      if (i == MAX_TAPS - 1) begin : g_tail
         assign w_next = 32'd0;
      end else begin : g_inner
         assign w_next = w_chain[i+1];
      end
      rfsc_cell u_cell (
         .clock  (clock),
         .ctrl   (cell_ctrl),
         .d_prev (d_prev),
         .w_next (w_next),
         .d_out  (d_chain[i]),
         .w_out  (w_chain[i])
      );
   end

   assign mac_ctrl.clear = (state_ff == ST_LOAD);
   assign mac_ctrl.issue = issue;
   assign mac_ctrl.mode  = row_plane_ff;

   rfsc_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .pix   (w_chain[0]),
      .tap   (taps_ff[tap_addr]),
      .acc   (acc),
      .busy  (mac_busy)
   );

   rfsc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_plane        = row_plane_ff;
   assign rsp_run_last     = rsp_last_ff;

endmodule

/* hw/rtl/rfsc_cell.sv */
// ----------------------------------------------------------------------------
// rfsc_cell
// One tap cell: a delay line entry and a work copy that walks to the head.
// ----------------------------------------------------------------------------
module rfsc_cell (
   input  logic                   clock,
   input  rfsc_pkg::cell_ctrl_type ctrl,
   input  logic [31:0]            d_prev,
   input  logic [31:0]            w_next,
   output logic [31:0]            d_out,
   output logic [31:0]            w_out
);
   import rfsc_pkg::*;

   logic [31:0] d_ff, d_in;
   logic [31:0] w_ff, w_in;

   always_comb begin
      d_in = ctrl.shift ? d_prev : d_ff;
      if (ctrl.load) begin
         w_in = d_ff;
      end else if (ctrl.rot) begin
         w_in = w_next;
      end else begin
         w_in = w_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      w_ff <= w_in;
   end

   assign d_out = d_ff;
   assign w_out = w_ff;

endmodule

/* hw/rtl/rfsc_mac.sv */
// ----------------------------------------------------------------------------
// rfsc_mac
// Shared multiply-accumulate pipe: product (pixel for quality), round and square (error only), accumulate.
// ----------------------------------------------------------------------------
module rfsc_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  rfsc_pkg::mac_ctrl_type ctrl,
   input  logic [31:0]           pix,
   input  logic [15:0]           tap,
   output logic [63:0]           acc,
   output logic                  busy
);
   import rfsc_pkg::*;

   logic        v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [63:0] s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [63:0] acc_ff, acc_in;

   logic [31:0]        mag;
   logic signed [32:0] op_a;
   logic signed [16:0] op_b;
   logic signed [49:0] prod;
   logic [63:0]        rnd;
   logic [64:0]        sat_sum;

   always_comb begin
      mag  = pix[31] ? (32'd0 - pix) : pix;
      op_a = (ctrl.mode == PLANE_SCI) ? $signed({pix[31], pix}) : $signed({1'b0, mag});
      op_b = $signed({1'b0, tap});
      prod = 50'(op_a) * 50'(op_b);
      if (ctrl.mode == PLANE_QUAL) begin
         s1_in = {48'd0, pix[15:0]};
      end else begin
         s1_in = {{14{prod[49]}}, prod};
      end

      rnd = s1_ff + 64'd32768;
      s2_in = (ctrl.mode == PLANE_ERR) ? {32'd0, rnd[47:16]} : s1_ff;
      s3_in = (ctrl.mode == PLANE_ERR) ? (s2_ff[31:0] * s2_ff[31:0]) : s2_ff;

      sat_sum = {1'b0, acc_ff} + {1'b0, s3_ff};
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         acc_in = 64'd0;
      end else if (v3_ff) begin
         case (ctrl.mode)
            PLANE_SCI:  acc_in = acc_ff + s3_ff;
            PLANE_ERR:  acc_in = sat_sum[64] ? {64{1'b1}} : sat_sum[63:0];
            PLANE_QUAL: acc_in = acc_ff | s3_ff;
            default:    acc_in = acc_ff;
         endcase
      end

      v1_in = ctrl.issue;
      v2_in = v1_ff;
      v3_in = v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = v1_ff | v2_ff | v3_ff;

endmodule

/* hw/rtl/rfsc_sqrt.sv */
// ----------------------------------------------------------------------------
// rfsc_sqrt
// Bit-serial rounded square root of a 64-bit value, saturated to 31 bits.
// ----------------------------------------------------------------------------
module rfsc_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import rfsc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] trial, rounded;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      root_in = root_ff;
      trial   = res_ff + bit_ff;
      rounded = res_ff + ((rem_ff > res_ff) ? 64'd1 : 64'd0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         rem_in  = radicand;
         res_in  = 64'd0;
         bit_in  = 64'd1 << 62;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            root_in = (rounded > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rounded[31:0];
         end else begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* hw/rtl/rfsc_checker.sv */
// ----------------------------------------------------------------------------
// rfsc_checker
// Port-level checks for the row FIR smear convolver.
// ----------------------------------------------------------------------------
module rfsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_result_value,
   input logic [1:0]         rsp_plane,
   input logic               rsp_run_last
);
   import rfsc_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("result item changed while stalled");

   // no new item is taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_qual_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_plane == PLANE_QUAL |-> rsp_result_value[31:16] == 16'd0)
      else $error("quality result wider than 16 bits");

   // a further result of the same item needs a fresh window pass
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> !rsp_valid && req_stall)
      else $error("result burst without window pass");

   a_plane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_plane != 2'd3)
      else $error("bad plane code");

endmodule

bind row_fir_smear_convolver_top rfsc_checker u_rfsc_checker (.*);
